>>> hw/rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes of the k-way sorted merge: command and status
// codes, controller states and the reset value of the lists-in-use register.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_POP   = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   // Response status codes
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_UNUSED = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_POP_CNT,
      S_POP_HEAD,
      S_DONE
   } state_type;

   // Width and reset value of the lists-in-use register
   localparam int USE_W = 4;
   localparam logic [USE_W-1:0] USE_RESET = 4'd8;

endpackage : kwm_pkg

`default_nettype wire

>>> hw/rtl/k_way_sorted_merge_top.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Merges up to NUM_LISTS ascending lists into one ascending stream. Elements
// live in an element RAM, per-list fill count and read position in a small
// count RAM; each list's current head sits in a register and a registered
// minimum tree over the heads picks the smallest (lower list on a tie).
//
//   channel | ports                       | direction | handshake
//   --------+-----------------------------+-----------+------------------
//   req     | command, array_select,value | in        | req_valid/ready
//   rsp     | status, merged_value,source | out       | rsp_valid/ready
//   csr     | write_enable, write_data    | in        | write, no wait
//
// One request at a time. Clear, no-op, load to an unused list, empty pop: exec,
// done; load: exec, load, done; pop: exec, count, head refill from the element
// RAM only when the list has a next element, done. After each request and each
// csr write the min tree settles level by level before req_ready returns.
// Reset is synchronous and takes effect at once; the RAMs are not cleared.
// A held response stalls only the final step; the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_top #(
   parameter int NUM_LISTS   = 8,
   parameter int LIST_DEPTH  = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_command,
   input  wire logic [2:0]               req_array_select,
   input  wire logic signed [31:0]       req_value,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [31:0]            rsp_merged_value,
   output logic [2:0]                    rsp_source_array,
   // configuration
   input  wire logic                     csr_write_enable,
   input  wire logic [kwm_pkg::USE_W-1:0] csr_write_data
);

   import kwm_pkg::*;

   // Derived sizes
   localparam int LIST_W     = $clog2(NUM_LISTS);
   localparam int N2         = 1 << LIST_W;
   localparam int LVL        = LIST_W;
   localparam int POS_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int USED_W     = $clog2(NUM_LISTS + 1);
   localparam int CW         = (USED_W > USE_W) ? USED_W : USE_W;
   localparam int SET_W      = $clog2(LVL + 1);
   localparam int ELEM_DEPTH = NUM_LISTS * (1 << POS_W);
   localparam int ELEM_AW    = LIST_W + POS_W;

   // Controller and request registers
   state_type                state_ff, state_in;
   command_type              cmd_ff;
   logic [2:0]               sel_ff;
   logic signed [31:0]       value_ff;
   logic [LIST_W-1:0]        work_list_ff, work_list_in;
   logic [SET_W-1:0]         settle_ff, settle_in;
   logic [USE_W-1:0]         arrays_in_use_ff;

   // Result held until the output register is free
   status_type               res_status_ff, res_status_in;
   logic signed [31:0]       res_value_ff, res_value_in;
   logic [2:0]               res_source_ff, res_source_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic signed [31:0]       rsp_value_ff;
   logic [2:0]               rsp_source_ff;
   logic                     rsp_load;

   // Per-list heads and count-entry valid bits
   logic                          head_valid_ff [N2];
   logic signed [VALUE_WIDTH-1:0] head_value_ff [N2];
   logic                          cnt_valid_ff  [N2];
   logic                          head_wr_en;
   logic signed [VALUE_WIDTH-1:0] head_wr_value;
   logic                          head_valid_set;
   logic                          head_valid_clr;
   logic                          cnt_valid_set;
   logic                          clear_all;

   // Count RAM: {fill, read position} per list
   logic                    cnt_wr_en;
   logic [2*CNT_W-1:0]      cnt_wr_data;
   logic [LIST_W-1:0]       cnt_rd_addr;
   logic [2*CNT_W-1:0]      cnt_rd_data;
   logic [CNT_W-1:0]        cur_fill;
   logic [CNT_W-1:0]        cur_rdpos;
   logic [CNT_W-1:0]        next_rdpos;

   // Element RAM
   logic                          elem_wr_en;
   logic [ELEM_AW-1:0]            elem_wr_addr;
   logic signed [VALUE_WIDTH-1:0] elem_wr_data;
   logic [ELEM_AW-1:0]            elem_rd_addr;
   logic [VALUE_WIDTH-1:0]        elem_rd_data;

   // Min tree: nodes 1..N2-1 registered, N2..2*N2-1 are the heads
   logic                          nd_valid_ff [1:N2-1];
   logic [LIST_W-1:0]             nd_index_ff [1:N2-1];
   logic signed [VALUE_WIDTH-1:0] nd_value_ff [1:N2-1];
   logic                          tr_valid_in [1:N2-1];
   logic [LIST_W-1:0]             tr_index_in [1:N2-1];
   logic signed [VALUE_WIDTH-1:0] tr_value_in [1:N2-1];
   logic                          all_valid   [1:2*N2-1];
   logic [LIST_W-1:0]             all_index   [1:2*N2-1];
   logic signed [VALUE_WIDTH-1:0] all_value   [1:2*N2-1];

   // Decoded conditions
   logic [CW-1:0]           used_c;
   logic [CW-1:0]           arrays_ext;
   logic [CW-1:0]           sel_ext;
   logic [CW-1:0]           root_index_ext;
   logic                    sel_in_use;
   logic                    root_valid;
   logic                    load_full;
   logic                    pop_more;

   // ------------------------------------------------------------------------
   // Lists in use and request checks
   // ------------------------------------------------------------------------
   assign arrays_ext     = CW'(arrays_in_use_ff);
   assign used_c         = (arrays_ext > CW'(NUM_LISTS)) ? CW'(NUM_LISTS) : arrays_ext;
   assign sel_ext        = CW'(sel_ff);
   assign sel_in_use     = (sel_ext < used_c);
   assign root_valid     = all_valid[1];
   assign root_index_ext = CW'(all_index[1]);

   // Count entry of the working list; an entry never written reads as zero
   assign cur_fill   = cnt_valid_ff[work_list_ff] ? cnt_rd_data[2*CNT_W-1:CNT_W] : '0;
   assign cur_rdpos  = cnt_valid_ff[work_list_ff] ? cnt_rd_data[CNT_W-1:0] : '0;
   assign next_rdpos = cur_rdpos + CNT_W'(1);
   assign load_full  = (cur_fill >= CNT_W'(LIST_DEPTH));
   assign pop_more   = (next_rdpos < cur_fill);

   // ------------------------------------------------------------------------
   // Min tree: leaves from the heads, one level per register stage
   // ------------------------------------------------------------------------
   always_comb begin
      for (int n = 1; n < N2; n++) begin
         all_valid[n] = nd_valid_ff[n];
         all_index[n] = nd_index_ff[n];
         all_value[n] = nd_value_ff[n];
      end
      for (int i = 0; i < N2; i++) begin
         all_valid[N2+i] = head_valid_ff[i] && (CW'(i) < used_c);
         all_index[N2+i] = LIST_W'(i);
         all_value[N2+i] = head_value_ff[i];
      end
   end

   always_comb begin
      int  l;
      int  r;
      logic take_r;
      for (int n = 1; n < N2; n++) begin
         l      = 2 * n;
         r      = 2 * n + 1;
         take_r = all_valid[r] && (!all_valid[l] || (all_value[r] < all_value[l]));
         tr_valid_in[n] = all_valid[l] || all_valid[r];
         tr_index_in[n] = take_r ? all_index[r] : all_index[l];
         tr_value_in[n] = take_r ? all_value[r] : all_value[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 1; n < N2; n++) begin
         nd_valid_ff[n] <= tr_valid_in[n];
         nd_index_ff[n] <= tr_index_in[n];
         nd_value_ff[n] <= tr_value_in[n];
      end
   end

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff) inside
               CMD_LOAD: state_in = sel_in_use ? S_LOAD : S_DONE;
               CMD_POP:  state_in = root_valid ? S_POP_CNT : S_DONE;
               CMD_CLEAR, CMD_NOP: state_in = S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_LOAD:     state_in = S_DONE;
         S_POP_CNT:  state_in = pop_more ? S_POP_HEAD : S_DONE;
         S_POP_HEAD: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      work_list_in   = work_list_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      res_source_in  = res_source_ff;
      cnt_rd_addr    = work_list_ff;
      cnt_wr_en      = 1'b0;
      cnt_wr_data    = {cur_fill, cur_rdpos};
      elem_wr_en     = 1'b0;
      elem_wr_addr   = {work_list_ff, cur_fill[POS_W-1:0]};
      elem_wr_data   = VALUE_WIDTH'(value_ff);
      elem_rd_addr   = {work_list_ff, next_rdpos[POS_W-1:0]};
      head_wr_en     = 1'b0;
      head_wr_value  = VALUE_WIDTH'(value_ff);
      head_valid_set = 1'b0;
      head_valid_clr = 1'b0;
      cnt_valid_set  = 1'b0;
      clear_all      = 1'b0;
      rsp_load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
         end
         S_EXEC: begin
            res_status_in = STAT_OK;
            res_value_in  = '0;
            res_source_in = '0;
            unique case (cmd_ff)
               CMD_CLEAR: clear_all = 1'b1;
               CMD_LOAD: begin
                  if (!sel_in_use) begin
                     res_status_in = STAT_UNUSED;
                  end
                  work_list_in = sel_ext[LIST_W-1:0];
                  cnt_rd_addr  = sel_ext[LIST_W-1:0];
               end
               CMD_POP: begin
                  if (!root_valid) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     res_value_in  = 32'(all_value[1]);
                     res_source_in = root_index_ext[2:0];
                  end
                  work_list_in = all_index[1];
                  cnt_rd_addr  = all_index[1];
               end
               CMD_NOP: begin
               end
               default: begin
               end
            endcase
         end
         S_LOAD: begin
            // Append at the fill position unless the list is full; an empty list takes it as head
            if (load_full) begin
               res_status_in = STAT_FULL;
            end else begin
               elem_wr_en    = 1'b1;
               cnt_wr_en     = 1'b1;
               cnt_wr_data   = {cur_fill + CNT_W'(1), cur_rdpos};
               cnt_valid_set = 1'b1;
               if (!head_valid_ff[work_list_ff]) begin
                  head_wr_en     = 1'b1;
                  head_valid_set = 1'b1;
               end
            end
         end
         S_POP_CNT: begin
            // Advance the read position; fetch the next head if any
            cnt_wr_en   = 1'b1;
            cnt_wr_data = {cur_fill, next_rdpos};
            if (!pop_more) begin
               head_valid_clr = 1'b1;
            end
         end
         S_POP_HEAD: begin
            head_wr_en    = 1'b1;
            head_wr_value = elem_rd_data;
         end
         S_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // Settle count for the min tree after any head or register change
   always_comb begin
      settle_in = settle_ff;
      if (csr_write_enable || ((state_ff == S_DONE) && (state_in == S_IDLE))) begin
         settle_in = SET_W'(LVL);
      end else if ((state_ff == S_IDLE) && (settle_ff != '0)) begin
         settle_in = settle_ff - SET_W'(1);
      end
   end

   // Output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         settle_ff        <= SET_W'(LVL);
         rsp_valid_ff     <= 1'b0;
         arrays_in_use_ff <= USE_RESET;
         for (int i = 0; i < N2; i++) begin
            head_valid_ff[i] <= 1'b0;
            cnt_valid_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            arrays_in_use_ff <= csr_write_data;
         end
         if (clear_all) begin
            for (int i = 0; i < N2; i++) begin
               head_valid_ff[i] <= 1'b0;
               cnt_valid_ff[i]  <= 1'b0;
            end
         end else begin
            if (head_valid_set) begin
               head_valid_ff[work_list_ff] <= 1'b1;
            end else if (head_valid_clr) begin
               head_valid_ff[work_list_ff] <= 1'b0;
            end
            if (cnt_valid_set) begin
               cnt_valid_ff[work_list_ff] <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= command_type'(req_command);
         sel_ff   <= req_array_select;
         value_ff <= req_value;
      end
      work_list_ff  <= work_list_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_source_ff <= res_source_in;
      if (head_wr_en) begin
         head_value_ff[work_list_ff] <= head_wr_value;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_source_ff <= res_source_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------------
   kwm_ram #(
      .WIDTH (2 * CNT_W),
      .DEPTH (NUM_LISTS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (work_list_ff),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   kwm_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (ELEM_DEPTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   // ------------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------------
   assign req_ready        = (state_ff == S_IDLE) && (settle_ff == '0);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_source_array = rsp_source_ff;

endmodule : k_way_sorted_merge_top

`default_nettype wire

>>> hw/rtl/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No reset on the contents.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : kwm_ram

`default_nettype wire
